// File: sv/tcsr_pkg.sv
package tcsr_pkg;

   localparam int SAMPLE_WIDTH = 32;
   localparam int SUM_WIDTH = 64;
   localparam int PREC_WIDTH = 16;
   localparam int T_WIDTH = 16;
   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam logic [PREC_WIDTH-1:0] PREC_RESET = 16'd1229;
   localparam logic [T_WIDTH-1:0] T_FAR = 16'd8036;

   // t in q4.12 for df 1..40
   function automatic logic [T_WIDTH-1:0] t_small(input logic [5:0] df);
      logic [T_WIDTH-1:0] r;
      begin
         case (df)
            6'd1: r = 16'd52044;  6'd2: r = 16'd17625;  6'd3: r = 16'd13033;
            6'd4: r = 16'd11370;  6'd5: r = 16'd10531;  6'd6: r = 16'd10023;
            6'd7: r = 16'd9687;   6'd8: r = 16'd9445;   6'd9: r = 16'd9265;
            6'd10: r = 16'd9126;  6'd11: r = 16'd9015;  6'd12: r = 16'd8925;
            6'd13: r = 16'd8847;  6'd14: r = 16'd8786;  6'd15: r = 16'd8729;
            6'd16: r = 16'd8684;  6'd17: r = 16'd8643;  6'd18: r = 16'd8606;
            6'd19: r = 16'd8573;  6'd20: r = 16'd8544;  6'd21: r = 16'd8520;
            6'd22: r = 16'd8495;  6'd23: r = 16'd8475;  6'd24: r = 16'd8454;
            6'd25: r = 16'd8438;  6'd26: r = 16'd8421;  6'd27: r = 16'd8405;
            6'd28: r = 16'd8389;  6'd29: r = 16'd8376;  6'd30: r = 16'd8364;
            6'd31: r = 16'd8356;  6'd32: r = 16'd8344;  6'd33: r = 16'd8335;
            6'd34: r = 16'd8323;  6'd35: r = 16'd8315;  6'd36: r = 16'd8307;
            6'd37: r = 16'd8298;  6'd38: r = 16'd8290;  6'd39: r = 16'd8286;
            6'd40: r = 16'd8278;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   typedef struct packed {
      logic [9:0] lo_df;
      logic [9:0] dx;
      logic [10:0] lo_m;
      logic [10:0] hi_m;
   } seg_type;

   function automatic seg_type t_seg(input logic [9:0] df);
      seg_type s;
      begin
         if (df <= 10'd45) s = '{10'd40, 10'd5, 11'd2021, 11'd2014};
         else if (df <= 10'd50) s = '{10'd45, 10'd5, 11'd2014, 11'd2009};
         else if (df <= 10'd55) s = '{10'd50, 10'd5, 11'd2009, 11'd2004};
         else if (df <= 10'd60) s = '{10'd55, 10'd5, 11'd2004, 11'd2000};
         else if (df <= 10'd70) s = '{10'd60, 10'd10, 11'd2000, 11'd1994};
         else if (df <= 10'd80) s = '{10'd70, 10'd10, 11'd1994, 11'd1990};
         else if (df <= 10'd90) s = '{10'd80, 10'd10, 11'd1990, 11'd1987};
         else if (df <= 10'd100) s = '{10'd90, 10'd10, 11'd1987, 11'd1984};
         else if (df <= 10'd150) s = '{10'd100, 10'd50, 11'd1984, 11'd1976};
         else if (df <= 10'd200) s = '{10'd150, 10'd50, 11'd1976, 11'd1972};
         else if (df <= 10'd250) s = '{10'd200, 10'd50, 11'd1972, 11'd1969};
         else if (df <= 10'd300) s = '{10'd250, 10'd50, 11'd1969, 11'd1968};
         else if (df <= 10'd400) s = '{10'd300, 10'd100, 11'd1968, 11'd1966};
         else if (df <= 10'd500) s = '{10'd400, 10'd100, 11'd1966, 11'd1965};
         else if (df <= 10'd600) s = '{10'd500, 10'd100, 11'd1965, 11'd1964};
         else if (df <= 10'd700) s = '{10'd600, 10'd100, 11'd1964, 11'd1963};
         else if (df <= 10'd800) s = '{10'd700, 10'd100, 11'd1963, 11'd1963};
         else if (df <= 10'd900) s = '{10'd800, 10'd100, 11'd1963, 11'd1963};
         else s = '{10'd900, 10'd100, 11'd1963, 11'd1962};
         return s;
      end
   endfunction

endpackage

// File: sv/tcsr_if.sv
interface tcsr_req_if;
   logic valid;
   logic ready;
   logic signed [tcsr_pkg::SAMPLE_WIDTH-1:0] sample_value;
   modport source (output valid, output sample_value, input ready);
   modport sink (input valid, input sample_value, output ready);
endinterface

interface tcsr_rsp_if;
   logic valid;
   logic ready;
   logic keep_sampling;
   logic signed [31:0] running_mean;
   logic [31:0] samples_taken;
   logic [tcsr_pkg::T_WIDTH-1:0] t_value;
   modport source (output valid, output keep_sampling, output running_mean,
                   output samples_taken, output t_value, input ready);
   modport sink (input valid, input keep_sampling, input running_mean,
                 input samples_taken, input t_value, output ready);
endinterface

// File: sv/t_confidence_stopping_rule.sv
// flow: request taken in S_IDLE, sum updated in S_SUM, serial units started in S_START,
//   response registered from S_WAIT once the mean divide, p^2*n and t^2 are all done
// one sample at a time, paced by the 64-step serial mean divider (t interpolation, p^2*n
//   and t^2 run alongside it); a stalled response holds the block; the next request is
//   taken in the cycle after the response transaction
// reset: synchronous active high; clears sum, count, differ flag, sets precision to 1229
module t_confidence_stopping_rule #(
   parameter int COUNT_WIDTH = tcsr_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   tcsr_req_if.sink                           req,
   tcsr_rsp_if.source                         rsp,
   input  logic                               csr_write_enable,
   input  logic [tcsr_pkg::PREC_WIDTH-1:0]    csr_write_data
);
   typedef enum logic [2:0] {S_IDLE, S_SUM, S_START, S_WAIT, S_OUT} state_type;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   state_type state_ff;
   logic [tcsr_pkg::PREC_WIDTH-1:0] prec_ff;
   logic signed [63:0] sum_ff;
   logic [COUNT_WIDTH-1:0] cnt_ff;
   logic [31:0] first_ff;
   logic differ_ff;
   logic signed [31:0] x_ff;
   logic neg_ff;
   logic [tcsr_pkg::T_WIDTH-1:0] t_ff;
   logic [63:0] q_ff, p2n_ff;
   logic [31:0] tt_ff;
   logic tdone_ff, ddone_ff, pdone_ff, sqgo_ff, sqdone_ff;

   logic signed [64:0] sum_wide;
   logic [63:0] mag;
   logic [31:0] df;
   logic start_calc, start_t, start_sq, all_done;
   logic div_done, tdiv_done, p2_done, p2n_done, sq_done;
   logic [63:0] quot;
   logic [15:0] tdiv_q;
   logic [31:0] p2;
   logic [32+COUNT_WIDTH-1:0] p2n_full;
   logic [31:0] tsq;
   logic [15:0] t_pick;
   logic [31:0] mean_sat;

   // sum update with signed saturation, taken from the widened sum
   assign sum_wide = 65'(sum_ff) + 65'(x_ff);
   assign mag = sum_ff[63] ? (64'd0 - sum_ff) : sum_ff;
   // degrees of freedom in 32 bits whatever the count width
   assign df = 32'(cnt_ff) - 32'd1;
   assign start_calc = (state_ff == S_START);
   // t^2 starts once t is settled, from the table or the interpolation divide
   assign start_sq = (state_ff == S_WAIT) && tdone_ff && !sqgo_ff;
   assign all_done = ddone_ff && pdone_ff && sqdone_ff;
   assign req.ready = (state_ff == S_IDLE);

   // t: zero for a count of 0 or 1, table below 41, constant above 1000, else serial interpolation divide
   always_comb begin
      t_pick = '0;
      start_t = 1'b0;
      if (cnt_ff <= COUNT_WIDTH'(1)) t_pick = '0;
      else if (df <= 32'd40) t_pick = tcsr_pkg::t_small(df[5:0]);
      else if (df > 32'd1000) t_pick = tcsr_pkg::T_FAR;
      else start_t = 1'b1;
   end

   tcsr_div #(.COUNT_WIDTH(COUNT_WIDTH)) u_div (
      .clock(clock), .reset(reset), .start(start_calc), .dividend(mag),
      .divisor(cnt_ff), .done(div_done), .quotient(quot));

   tcsr_tdiv u_tdiv (
      .clock(clock), .reset(reset), .start(start_calc && start_t),
      .df(df[9:0]), .done(tdiv_done), .t_q(tdiv_q));

   // p^2 then p^2 * n
   tcsr_mul #(.AW(16), .BW(16)) u_p2 (
      .clock(clock), .reset(reset), .start(start_calc), .a(prec_ff), .b(prec_ff),
      .done(p2_done), .product(p2));

   tcsr_mul #(.AW(32), .BW(COUNT_WIDTH)) u_p2n (
      .clock(clock), .reset(reset), .start(p2_done), .a(p2), .b(cnt_ff),
      .done(p2n_done), .product(p2n_full));

   // t^2
   tcsr_mul #(.AW(16), .BW(16)) u_tsq (
      .clock(clock), .reset(reset), .start(start_sq), .a(t_ff), .b(t_ff),
      .done(sq_done), .product(tsq));

   // saturated signed mean
   always_comb begin
      if (neg_ff) mean_sat = (q_ff > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q_ff);
      else mean_sat = (q_ff > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         prec_ff <= tcsr_pkg::PREC_RESET;
         sum_ff <= '0;
         cnt_ff <= '0;
         differ_ff <= 1'b0;
         rsp.valid <= 1'b0;
         tdone_ff <= 1'b0; ddone_ff <= 1'b0; pdone_ff <= 1'b0;
         sqgo_ff <= 1'b0; sqdone_ff <= 1'b0;
      end else begin
         if (csr_write_enable) prec_ff <= csr_write_data;
         case (state_ff)
            S_IDLE: begin
               // request transaction: first sample, differ flag and count
               if (req.valid) begin
                  x_ff <= req.sample_value;
                  if (cnt_ff == '0) first_ff <= req.sample_value;
                  else if (req.sample_value != first_ff) differ_ff <= 1'b1;
                  if (cnt_ff != CNT_MAX) cnt_ff <= cnt_ff + COUNT_WIDTH'(1);
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               // saturate when the 65-bit sum leaves the signed 64-bit range
               if (sum_wide[64] != sum_wide[63])
                  sum_ff <= sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
               else
                  sum_ff <= sum_wide[63:0];
               state_ff <= S_START;
            end
            S_START: begin
               // serial units start on the updated sum and count
               neg_ff <= sum_ff[63];
               t_ff <= t_pick;
               tdone_ff <= !start_t;
               ddone_ff <= 1'b0; pdone_ff <= 1'b0; sqgo_ff <= 1'b0; sqdone_ff <= 1'b0;
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (tdiv_done) begin
                  t_ff <= tdiv_q; tdone_ff <= 1'b1;
               end
               if (start_sq) sqgo_ff <= 1'b1;
               if (sq_done) begin
                  tt_ff <= tsq; sqdone_ff <= 1'b1;
               end
               if (div_done) begin
                  q_ff <= quot; ddone_ff <= 1'b1;
               end
               if (p2n_done) begin
                  p2n_ff <= 64'(p2n_full); pdone_ff <= 1'b1;
               end
               if (all_done) begin
                  rsp.valid <= 1'b1;
                  rsp.samples_taken <= 32'(cnt_ff);
                  rsp.t_value <= t_ff;
                  rsp.running_mean <= mean_sat;
                  // few samples keep going, equal samples stop, else t^2 > p^2*n
                  if (cnt_ff <= COUNT_WIDTH'(1)) rsp.keep_sampling <= 1'b1;
                  else if (!differ_ff) rsp.keep_sampling <= 1'b0;
                  else rsp.keep_sampling <= ({32'd0, tt_ff} > p2n_ff);
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               // hold the response transaction until it is taken
               if (rsp.ready) begin
                  rsp.valid <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: sv/tcsr_div.sv
// restoring divider, one quotient bit per cycle, 64 / count
module tcsr_div #(
   parameter int COUNT_WIDTH = tcsr_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [63:0]            dividend,
   input  logic [COUNT_WIDTH-1:0] divisor,
   output logic                   done,
   output logic [63:0]            quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [COUNT_WIDTH:0] rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0] dvs_ff, dvs_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [COUNT_WIDTH+1:0] trial;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[63]} - {2'b00, dvs_ff};
      if (start) begin
         quo_in = dividend; rem_in = '0; dvs_in = divisor;
         cnt_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[COUNT_WIDTH+1]) begin
            rem_in = trial[COUNT_WIDTH:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[COUNT_WIDTH-1:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

// File: sv/tcsr_mul.sv
// shift-add multiplier, one multiplier bit per cycle
module tcsr_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic             done,
   output logic [AW+BW-1:0] product
);
   localparam int CW = $clog2(BW + 1);
   logic [AW+BW-1:0] acc_ff, acc_in, a_ff, a_in;
   logic [BW-1:0] b_ff, b_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in = acc_ff; a_in = a_ff; b_in = b_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         acc_in = '0; a_in = {{BW{1'b0}}, a}; b_in = b;
         cnt_in = CW'(BW); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) acc_in = acc_ff + a_ff;
         a_in = {a_ff[AW+BW-2:0], 1'b0};
         b_in = b_ff >> 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; a_ff <= a_in; b_ff <= b_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule

// File: sv/tcsr_tdiv.sv
// interpolated t: (num*4096 + den/2) / den, one quotient bit per cycle
module tcsr_tdiv (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [9:0]  df,
   output logic        done,
   output logic [15:0] t_q
);
   tcsr_pkg::seg_type seg;
   logic [31:0] dvd_ff, dvd_in;
   logic [17:0] den_ff, den_in;
   logic [18:0] rem_ff, rem_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [19:0] trial;
   logic [19:0] num;
   logic [17:0] den;

   always_comb begin
      seg = tcsr_pkg::t_seg(df);
      den = 18'(seg.dx) * 18'd1000;
      num = 20'(seg.lo_m) * 20'(seg.dx)
          - 20'(seg.lo_m - seg.hi_m) * 20'(df - seg.lo_df);
      dvd_in = dvd_ff; den_in = den_ff; rem_in = rem_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, dvd_ff[31]} - {2'b00, den_ff};
      if (start) begin
         dvd_in = {num, 12'd0} + 32'(den[17:1]);
         den_in = den; rem_in = '0; cnt_in = 6'd32; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[19]) begin
            rem_in = trial[18:0]; dvd_in = {dvd_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[17:0], dvd_ff[31]}; dvd_in = {dvd_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in; den_ff <= den_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign t_q = dvd_ff[15:0];
endmodule

// File: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PREC_WIDTH = tcsr_pkg::PREC_WIDTH;
   localparam int T_WIDTH = tcsr_pkg::T_WIDTH;

   // drain allowance, waited out once every expected response is back
   localparam int DRAIN_CYCLES = 100;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [PREC_WIDTH-1:0] csr_write_data;

   tcsr_req_if req_ch ();
   tcsr_rsp_if rsp_ch ();

   t_confidence_stopping_rule dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch.sink),
      .rsp              (rsp_ch.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // one expected response transaction
   typedef struct {
      logic                keep_sampling;
      logic signed [31:0]  running_mean;
      logic [31:0]         samples_taken;
      logic [T_WIDTH-1:0]  t_value;
   } verdict_type;

   verdict_type pending_verdicts[$];

   // predictor state, mirrors the block after reset
   logic [PREC_WIDTH-1:0] model_precision = tcsr_pkg::PREC_RESET;
   logic signed [63:0]    model_sum = '0;
   logic [31:0]           model_count = '0;
   logic [31:0]           model_first = '0;
   logic                  model_differ = 1'b0;

   int mismatch_count = 0;
   int rsp_hold_cycles = 0;   // long receiver hold-off, counted down by the receiver
   bit rsp_busy_mode = 1'b0;  // 1 selects random receiver stalls, 0 a stretch of none
   bit tx_busy_mode = 1'b0;

   // clock, 8 ns period
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // two-tailed 95% t in q4.12 for the given degrees of freedom
   function automatic logic [T_WIDTH-1:0] student_t_q412(input longint unsigned df);
      int unsigned milli_small[40] = '{
         12706, 4303, 3182, 2776, 2571, 2447, 2365, 2306, 2262, 2228,
         2201, 2179, 2160, 2145, 2131, 2120, 2110, 2101, 2093, 2086,
         2080, 2074, 2069, 2064, 2060, 2056, 2052, 2048, 2045, 2042,
         2040, 2037, 2035, 2032, 2030, 2028, 2026, 2024, 2023, 2021};
      int unsigned knot_df[20] = '{
         40, 45, 50, 55, 60, 70, 80, 90, 100, 150,
         200, 250, 300, 400, 500, 600, 700, 800, 900, 1000};
      int unsigned knot_milli[20] = '{
         2021, 2014, 2009, 2004, 2000, 1994, 1990, 1987, 1984, 1976,
         1972, 1969, 1968, 1966, 1965, 1964, 1963, 1963, 1963, 1962};
      longint unsigned span, num, den;
      if (df == 0) return '0;
      if (df <= 40) return T_WIDTH'((longint'(milli_small[df-1]) * 4096 + 500) / 1000);
      for (int i = 0; i < 19; i++) begin
         if (df <= knot_df[i+1]) begin
            span = knot_df[i+1] - knot_df[i];
            num = knot_milli[i] * span - (knot_milli[i] - knot_milli[i+1]) * (df - knot_df[i]);
            den = 1000 * span;
            return T_WIDTH'((num * 4096 + den / 2) / den);
         end
      end
      return T_WIDTH'((64'd1962 * 4096 + 500) / 1000);
   endfunction

   // advance the accumulator with one sample and queue the response it causes
   task automatic predict_sample(input logic signed [31:0] x);
      verdict_type v;
      logic signed [64:0] wide_sum;
      logic [63:0] mag, quot, t_sq, p_sq;
      logic neg;
      if (model_count == 0) model_first = x;
      else if (x != model_first) model_differ = 1'b1;
      // saturating 64-bit sum
      wide_sum = 65'(model_sum) + 65'(x);
      if (wide_sum > 65'sh7FFF_FFFF_FFFF_FFFF) model_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (wide_sum < -65'sh8000_0000_0000_0000) model_sum = 64'sh8000_0000_0000_0000;
      else model_sum = wide_sum[63:0];
      if (model_count != 32'hFFFF_FFFF) model_count++;
      // truncated mean, clamped to 32 bits
      neg = model_sum < 0;
      mag = neg ? -model_sum : model_sum;
      quot = mag / model_count;
      if (neg) v.running_mean = (quot > 64'h8000_0000) ? 32'sh8000_0000 : -quot[31:0];
      else v.running_mean = (quot > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quot[31:0];
      v.samples_taken = model_count;
      if (model_count <= 1) begin
         v.t_value = '0;
         v.keep_sampling = 1'b1;
      end else begin
         v.t_value = student_t_q412(model_count - 1);
         t_sq = 64'(v.t_value) * 64'(v.t_value);
         p_sq = 64'(model_precision) * 64'(model_precision);
         // equal samples so far means zero variance: stop
         v.keep_sampling = model_differ && (t_sq > p_sq * 64'(model_count));
      end
      pending_verdicts.push_back(v);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   function automatic int pick_gap(input bit busy);
      if (!busy) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
      return $urandom_range(0, 3);
   endfunction

   // offer one transaction; called right after a rising edge
   task automatic send_sample(input logic signed [31:0] x);
      int gap;
      gap = pick_gap(tx_busy_mode);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.sample_value <= x;
      do @(posedge clock); while (!req_ch.ready);
      predict_sample(x);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_precision(input logic [PREC_WIDTH-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_precision = value;
   endtask

   function automatic logic signed [31:0] random_sample();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         2: return 32'sd1000 + $signed($urandom_range(0, 40)) - 32'sd20;
         default: return $signed($urandom_range(0, 2000)) - 32'sd1000;
      endcase
   endfunction

   // first samples all equal: keep while count <= 1, then stop on zero variance
   task automatic test_equal_samples();
      tx_busy_mode = 1'b0;
      rsp_busy_mode = 1'b0;
      repeat (4) send_sample(32'sh7FFF_FFFF);
   endtask

   // extremes of the sample field and precision extremes at small df
   task automatic test_extremes();
      send_sample(32'sh8000_0000);
      send_sample(32'sh8000_0000);
      send_sample(32'sd0);
      send_sample(-32'sd1);
      write_precision('0);
      send_sample(32'sd1);
      send_sample(32'sh5555_5555);
      write_precision(16'hFFFF);
      send_sample(-32'sh5555_5556);
      send_sample(32'sh7FFF_FFFF);
      write_precision(tcsr_pkg::PREC_RESET);
      send_sample(32'sd12345);
   endtask

   // receiver held off for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      tx_busy_mode = 1'b0;
      rsp_hold_cycles = 800;
      repeat (20) send_sample(random_sample());
   endtask

   // sender pauses until every response is back, then resumes
   task automatic test_drain_pause();
      wait_idle();
      repeat (10) send_sample(random_sample());
   endtask

   // long random run: count climbs through the interpolated region and past df 1000
   task automatic test_random_stream();
      for (int i = 0; i < 1050; i++) begin
         if (i % 150 == 0) begin
            // new precision each phase, mostly small so that keep stays interesting
            case ($urandom_range(0, 3))
               0: write_precision(16'($urandom_range(0, 300)));
               1: write_precision(16'($urandom()));
               2: write_precision($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
               default: write_precision(16'($urandom_range(100, 260)));
            endcase
            tx_busy_mode = 1'($urandom_range(0, 1));
            rsp_busy_mode = 1'($urandom_range(0, 1));
         end
         send_sample(random_sample());
      end
   endtask

   // receiver: random stalls, stretches with none, and the counted hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else if (!rsp_busy_mode) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 39) == 0) rsp_hold_cycles = $urandom_range(20, 60);
         end
      end
   end

   // response checker, compares every response transaction with the oldest expectation
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("unexpected response, count", rsp_ch.samples_taken, 0);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_ch.keep_sampling !== want.keep_sampling)
               report_mismatch("keep_sampling", rsp_ch.keep_sampling, want.keep_sampling);
            if (rsp_ch.running_mean !== want.running_mean)
               report_mismatch("running_mean", rsp_ch.running_mean, want.running_mean);
            if (rsp_ch.samples_taken !== want.samples_taken)
               report_mismatch("samples_taken", rsp_ch.samples_taken, want.samples_taken);
            if (rsp_ch.t_value !== want.t_value)
               report_mismatch("t_value", rsp_ch.t_value, want.t_value);
         end
      end
   end

   // test sequence
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.sample_value = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_equal_samples();
      test_extremes();
      test_backpressure();
      test_drain_pause();
      test_random_stream();
      wait_idle();
      // leftover expectations cannot remain here, wait_idle emptied the queue
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
